// ===== hdl/line_editor_erase_kill_buffer_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef LINE_EDITOR_ERASE_KILL_BUFFER_DEFINES_SVH
`define LINE_EDITOR_ERASE_KILL_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define LEKB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define LEKB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lekb_pkg.sv =====
package lekb_pkg;

    localparam int CHAR_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int LINE_DEPTH_DEF = 63;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic [CHAR_W-1:0] ERASE_RST    = 8'd35;
    localparam logic [CHAR_W-1:0] KILL_RST     = 8'd92;
    localparam logic [CHAR_W-1:0] LINE_END_RST = 8'd64;
    localparam logic [CHAR_W-1:0] END_RST      = 8'd45;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ERASE    = 2'd0,
        CFG_KILL     = 2'd1,
        CFG_LINE_END = 2'd2,
        CFG_END      = 2'd3
    } lekb_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT,
        ST_NL
    } lekb_state_t;

endpackage

// ===== hdl/lekb_if.sv =====
interface lekb_in_if import lekb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface lekb_out_if import lekb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ===== hdl/line_editor_erase_kill_buffer.sv =====
// Channel   Dir  Payload                 Transfer
// in_ch     in   in_char[7:0]            valid & ready
// out_ch    out  out_char[7:0], last     valid & ready
// cfg       in   cfg_index, cfg_data     cfg_we
//
// Ordinary and editing characters are handled in idle, where in_ch.ready is high.
// During a flush every entry goes through the single read port of the line memory,
//   then the output register; the newline follows the last entry.
// Output stalls hold the flush; in_ch.ready stays low until the newline is loaded.
// Reset clears the fill count and loads '#', '\', '@', '-'; the memory is not cleared.
module line_editor_erase_kill_buffer
    import lekb_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAR_W-1:0]    cfg_data,
    lekb_in_if.sink              in_ch,
    lekb_out_if.source           out_ch
);

    localparam int FILL_W = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    localparam logic [FILL_W-1:0] DEPTH_FULL = FILL_W'(LINE_DEPTH);

    lekb_state_t         state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    logic [CHAR_W-1:0]   pend_char_reg, pend_char_next;

    logic [CHAR_W-1:0]   erase_reg, kill_reg, line_end_reg, end_reg;

    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;
    logic                out_free;

    logic [CHAR_W-1:0]   line_mem [LINE_DEPTH];
    logic [CHAR_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CHAR_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign mem_raddr = rd_idx_reg[ADDR_W-1:0];

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_char    = out_char_reg;
    assign out_ch.last_of_run = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_reg    <= ERASE_RST;
            kill_reg     <= KILL_RST;
            line_end_reg <= LINE_END_RST;
            end_reg      <= END_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ERASE:    erase_reg    <= cfg_data;
                CFG_KILL:     kill_reg     <= cfg_data;
                CFG_LINE_END: line_end_reg <= cfg_data;
                CFG_END:      end_reg      <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_char_reg <= pend_char_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    // Writes happen only in idle or at the end of a flush, and read data is used only
    // during a flush, so a used read never overlaps a write to the same entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= line_mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_char_next = pend_char_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_reg[ADDR_W-1:0];
        mem_wdata      = in_ch.in_char;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.in_char == end_reg)
                    begin
                        if (fill_reg != '0)
                        begin
                            rd_idx_next = '0;
                            state_next  = ST_FETCH;
                        end
                    end
                    else if (in_ch.in_char == erase_reg)
                    begin
                        if (fill_reg != '0)
                        begin
                            fill_next = fill_reg - FILL_W'(1);
                        end
                    end
                    else if (in_ch.in_char == kill_reg)
                    begin
                        fill_next = '0;
                    end
                    else if (in_ch.in_char == line_end_reg)
                    begin
                        rd_idx_next = '0;
                        state_next  = (fill_reg == '0) ? ST_NL : ST_FETCH;
                    end
                    else if (fill_reg == DEPTH_FULL)
                    begin
                        // flush first, store the character once the newline is out
                        pend_next      = 1'b1;
                        pend_char_next = in_ch.in_char;
                        rd_idx_next    = '0;
                        state_next     = ST_FETCH;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data_reg;
                    out_last_next  = 1'b0;
                    rd_idx_next    = rd_idx_reg + FILL_W'(1);
                    state_next     = ((rd_idx_reg + FILL_W'(1)) == fill_reg) ? ST_NL : ST_FETCH;
                end
            end
            ST_NL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = NEWLINE_CODE;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                    if (pend_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = pend_char_reg;
                        fill_next = FILL_W'(1);
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        fill_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lekb_checker.sv =====
`include "line_editor_erase_kill_buffer_defines.svh"

module lekb_checker
    import lekb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] out_char,
    input logic              out_last
);

    // a run always closes on the newline
    `LEKB_ASSERT_NOW(a_last_is_newline, out_valid && out_last, out_char == NEWLINE_CODE, "last_of_run on a character other than newline")

    // no input is taken while a run still has its newline to come
    `LEKB_ASSERT_NOW(a_no_input_mid_run, out_valid && !out_last, !in_ready, "input ready in the middle of a flushed run")

    `LEKB_ASSERT_NEXT(a_out_valid_held, out_valid && !out_ready, out_valid, "output valid dropped while stalled")

    `LEKB_ASSERT_NEXT(a_out_char_held, out_valid && !out_ready, $stable(out_char) && $stable(out_last), "output payload changed while stalled")

endmodule

bind line_editor_erase_kill_buffer lekb_checker u_lekb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.out_char),
    .out_last  (out_ch.last_of_run)
);

// ===== tb/tb_line_editor_erase_kill_buffer.sv =====
module tb_line_editor_erase_kill_buffer;
    import lekb_pkg::*;

    localparam int RANDOM_PER_SETUP = 10;
    localparam int SETTLE_CYCLES    = 20;
    localparam int CYCLE_LIMIT      = 1000000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } out_byte_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we;
    lekb_cfg_idx_t     cfg_index;
    logic [CHAR_W-1:0] cfg_data;

    lekb_in_if  in_if ();
    lekb_out_if out_if ();

    line_editor_erase_kill_buffer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    // Line editor state as the block should hold it
    logic [CHAR_W-1:0] line_chars [LINE_DEPTH_DEF];
    int unsigned       line_len;
    logic [CHAR_W-1:0] erase_code;
    logic [CHAR_W-1:0] kill_code;
    logic [CHAR_W-1:0] line_end_code;
    logic [CHAR_W-1:0] end_code;

    out_byte_t         expected_bytes [$];
    logic [CHAR_W-1:0] pending_chars [$];

    bit          in_taken = 1'b0;
    int          gap_left;
    int          burst_left;
    int          max_gap;
    logic [15:0] ready_pattern;

    int errors = 0;
    int chars_taken = 0;
    int bytes_seen = 0;
    int lines_seen = 0;
    int setups_run = 0;
    int cycle_count = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void flush_line();
        for (int k = 0; k < line_len; k++)
        begin
            expected_bytes.push_back('{ch: line_chars[k], last: 1'b0});
        end
        expected_bytes.push_back('{ch: NEWLINE_CODE, last: 1'b1});
        line_len = 0;
    endfunction

    // End takes priority, then erase, kill and line-end
    function automatic void edit_line(input logic [CHAR_W-1:0] ch);
        if (ch == end_code)
        begin
            if (line_len != 0)
                flush_line();
        end
        else if (ch == erase_code)
        begin
            if (line_len != 0)
                line_len--;
        end
        else if (ch == kill_code)
        begin
            line_len = 0;
        end
        else if (ch == line_end_code)
        begin
            flush_line();
        end
        else
        begin
            if (line_len >= LINE_DEPTH_DEF)
                flush_line();
            line_chars[line_len] = ch;
            line_len++;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] ordinary_char();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 255));
        while (c == erase_code || c == kill_code || c == line_end_code || c == end_code);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] special_char();
        case ($urandom_range(0, 3))
            0:       return erase_code;
            1:       return kill_code;
            2:       return line_end_code;
            default: return end_code;
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!in_if.valid || in_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_if.valid <= 1'b0;
            end
            else if (pending_chars.size() != 0)
            begin
                in_if.in_char <= pending_chars.pop_front();
                in_if.valid   <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, max_gap);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: rotate the stall pattern one place per cycle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
            out_if.ready  <= ready_pattern[15];
        end
    end

    always @(posedge clk)
    begin
        out_byte_t want;
        if (rst_n)
        begin
            in_taken = in_if.valid && in_if.ready;
            if (in_taken)
            begin
                edit_line(in_if.in_char);
                chars_taken++;
            end
            if (out_if.valid && out_if.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected output char %0d last %0b", $time,
                             out_if.out_char, out_if.last_of_run);
                    errors++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_if.out_char !== want.ch)
                    begin
                        $display("%0t: out_char expected %0d actual %0d", $time,
                                 want.ch, out_if.out_char);
                        errors++;
                    end
                    if (out_if.last_of_run !== want.last)
                    begin
                        $display("%0t: last_of_run expected %0b actual %0b", $time,
                                 want.last, out_if.last_of_run);
                        errors++;
                    end
                    bytes_seen++;
                    if (want.last)
                        lines_seen++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d chars waiting, %0d bytes outstanding", $time,
                     pending_chars.size(), expected_bytes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Wait until every transfer has gone through, then let the block settle
    task automatic drain();
        while (pending_chars.size() != 0 || in_if.valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input lekb_cfg_idx_t idx, input logic [CHAR_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_ERASE:    erase_code    = value;
            CFG_KILL:     kill_code     = value;
            CFG_LINE_END: line_end_code = value;
            CFG_END:      end_code      = value;
            default:      ;
        endcase
    endtask

    // Mostly well-formed lines with random content; some noise and stray specials
    task automatic queue_random_items(input int target);
        int added;
        int len;
        int pick;
        added = 0;
        while (added < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 6);
                repeat (len)
                begin
                    pending_chars.push_back(ordinary_char());
                    added++;
                    if ($urandom_range(0, 99) < 15)
                    begin
                        pending_chars.push_back(erase_code);
                        added++;
                    end
                    else if ($urandom_range(0, 99) < 4)
                    begin
                        pending_chars.push_back(kill_code);
                        added++;
                    end
                end
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    pending_chars.push_back(line_end_code);
                    added++;
                end
                else if (pick < 85)
                begin
                    pending_chars.push_back(end_code);
                    added++;
                end
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    pending_chars.push_back(CHAR_W'($urandom_range(0, 255)));
                    added++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    pending_chars.push_back(special_char());
                    added++;
                end
            end
        end
    endtask

    task automatic run_setup(input logic [CHAR_W-1:0] er, input logic [CHAR_W-1:0] ki,
                             input logic [CHAR_W-1:0] le, input logic [CHAR_W-1:0] en,
                             input logic [15:0] pattern, input int gap, input bit long_line);
        drain();
        write_reg(CFG_ERASE, er);
        write_reg(CFG_KILL, ki);
        write_reg(CFG_LINE_END, le);
        write_reg(CFG_END, en);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        ready_pattern = pattern;
        max_gap       = gap;
        // Overfill the line so that the full-buffer flush happens, then close it
        if (long_line)
        begin
            repeat (LINE_DEPTH_DEF + $urandom_range(1, 5))
                pending_chars.push_back(ordinary_char());
            pending_chars.push_back(end_code);
        end
        queue_random_items(RANDOM_PER_SETUP);
        setups_run++;
    endtask

    initial
    begin
        in_if.valid    = 1'b0;
        in_if.in_char  = '0;
        out_if.ready   = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ERASE;
        cfg_data       = '0;
        ready_pattern  = 16'($urandom | $urandom | 16'h0001);
        max_gap        = 4;
        gap_left       = 0;
        burst_left     = 1;
        line_len       = 0;
        erase_code     = ERASE_RST;
        kill_code      = KILL_RST;
        line_end_code  = LINE_END_RST;
        end_code       = END_RST;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset codes: specials on an empty line, editing, flushing, extreme bytes
        pending_chars.push_back(LINE_END_RST);
        pending_chars.push_back(END_RST);
        pending_chars.push_back(ERASE_RST);
        pending_chars.push_back("a");
        pending_chars.push_back("b");
        pending_chars.push_back(ERASE_RST);
        pending_chars.push_back("c");
        pending_chars.push_back(LINE_END_RST);
        pending_chars.push_back("x");
        pending_chars.push_back("y");
        pending_chars.push_back(KILL_RST);
        pending_chars.push_back("z");
        pending_chars.push_back(END_RST);
        pending_chars.push_back(8'h00);
        pending_chars.push_back(8'hFF);
        pending_chars.push_back(LINE_END_RST);
        pending_chars.push_back(END_RST);
        pending_chars.push_back("q");
        pending_chars.push_back(LINE_END_RST);
        pending_chars.push_back(KILL_RST);
        queue_random_items(RANDOM_PER_SETUP);
        setups_run++;

        run_setup(8'h00, 8'hFF, NEWLINE_CODE, 8'h80, 16'($urandom | $urandom | 16'h0001),
                  5, 1'b0);
        // Colliding codes: end shadows erase, kill shadows line-end
        run_setup(8'h41, 8'h42, 8'h42, 8'h41, 16'($urandom | 16'h8001), 3, 1'b0);
        run_setup(8'h07, 8'h7F, 8'h0D, 8'h04, 16'hFFFF, 0, 1'b0);
        run_setup(8'hFF, 8'h00, 8'h00, 8'hFF, 16'($urandom | $urandom | 16'h0001),
                  6, 1'b1);
        run_setup(8'h01, 8'hFE, 8'hFF, 8'h00, 16'($urandom_range(1, 16'hFFFF)), 2, 1'b0);

        drain();
        $display("Run covered %0d characters under %0d code setups", chars_taken, setups_run);
        $display("and checked %0d emitted bytes in %0d flushed lines.", bytes_seen, lines_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lekb_pkg.sv
hdl/lekb_if.sv
hdl/line_editor_erase_kill_buffer.sv
hdl/lekb_checker.sv
tb/tb_line_editor_erase_kill_buffer.sv
